/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked every clock, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/trs_pkg.sv */
// types, constants and helpers for the interpolated trs matrix block
package trs_pkg;

    localparam int TRANSLATION_WIDTH = 32;
    localparam int TW = TRANSLATION_WIDTH;

    localparam int ROT_W   = 34;
    localparam int MUL_A_W = (TW + 1 > ROT_W) ? TW + 1 : ROT_W;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int BLEND_SHIFT = 15;
    localparam int ENT_SHIFT   = 30;

    localparam logic [15:0] ALPHA_ONE = 16'd32768;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_QBLEND = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SBLEND = 5'd4;
    localparam logic [STEP_W-1:0] STEP_TBLEND = 5'd7;
    localparam logic [STEP_W-1:0] STEP_QPROD  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_QEND   = 5'd19;
    localparam logic [STEP_W-1:0] STEP_ROT    = 5'd20;
    localparam logic [STEP_W-1:0] STEP_ENTRY  = 5'd21;
    localparam logic [STEP_W-1:0] STEP_LAST   = 5'd30;

    localparam logic signed [ROT_W-1:0] ONE_Q30 = ROT_W'(1) << 30;
    localparam logic signed [MUL_P_W-1:0] BLEND_HALF = MUL_P_W'(1) << (BLEND_SHIFT - 1);
    localparam logic signed [MUL_P_W-1:0] ENT_HALF = MUL_P_W'(1) << (ENT_SHIFT - 1);
    localparam logic signed [23:0] ENT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] ENT_MIN = -24'sh800000;

    // quaternion product operands: yy zz xx xy wz xz wy yz wx
    localparam logic [1:0] QPAIR_A [9] = '{2'd2, 2'd3, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0};
    localparam logic [1:0] QPAIR_B [9] = '{2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd1};

    localparam logic [1:0] ENTRY_COL [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

    typedef struct packed {
        logic [2:0][TW-1:0] trans;
        logic [3:0][15:0]   quat;
        logic [2:0][23:0]   scale;
    } t_snap;

    function automatic logic [15:0] sat_alpha(logic [15:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

    function automatic logic [TW-1:0] fit_trans(logic [31:0] v);
        logic signed [63:0] e;
        e = 64'($signed(v));
        return e[TW-1:0];
    endfunction

    function automatic logic [31:0] trans_out(logic [TW-1:0] t);
        logic signed [63:0] e;
        e = 64'($signed(t));
        return e[31:0];
    endfunction

endpackage

/* src/trs_if.sv */
// request and result channel interfaces
interface trs_in_if import trs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic        [15:0] alpha;
    logic signed [31:0] translation_x;
    logic signed [31:0] translation_y;
    logic signed [31:0] translation_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;

    modport source (
        output valid, command, alpha, translation_x, translation_y, translation_z,
               quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
        input  ready
    );
    modport sink (
        input  valid, command, alpha, translation_x, translation_y, translation_z,
               quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
        output ready
    );
endinterface

interface trs_out_if import trs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [23:0] row0_col0;
    logic signed [23:0] row0_col1;
    logic signed [23:0] row0_col2;
    logic signed [31:0] row0_col3;
    logic signed [23:0] row1_col0;
    logic signed [23:0] row1_col1;
    logic signed [23:0] row1_col2;
    logic signed [31:0] row1_col3;
    logic signed [23:0] row2_col0;
    logic signed [23:0] row2_col1;
    logic signed [23:0] row2_col2;
    logic signed [31:0] row2_col3;

    modport source (
        output valid, row0_col0, row0_col1, row0_col2, row0_col3,
               row1_col0, row1_col1, row1_col2, row1_col3,
               row2_col0, row2_col1, row2_col2, row2_col3,
        input  ready
    );
    modport sink (
        input  valid, row0_col0, row0_col1, row0_col2, row0_col3,
               row1_col0, row1_col1, row1_col2, row1_col3,
               row2_col0, row2_col1, row2_col2, row2_col3,
        output ready
    );
endinterface

/* src/trs_store.sv */
// previous and current transform snapshot registers
module trs_store import trs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_new,
    output t_snap o_cur,
    output t_snap o_prev
);

    t_snap r_cur;
    t_snap r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_prev <= '0;
        end else if (i_push) begin
            r_prev <= r_cur;
            r_cur  <= i_new;
        end
    end

    assign o_cur  = r_cur;
    assign o_prev = r_prev;

endmodule

/* src/trs_mul.sv */
// shared signed multiplier with registered product
module trs_mul import trs_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* src/interpolated_trs_matrix.sv */
// top level: snapshot blend and trs matrix build on one shared multiplier
// a push request updates the snapshots and gives no result
// an evaluate request runs 31 sequencer steps (28 products on the single multiplier),
// then waits in a hold state until the result register is free and loads it
// requests are accepted only while idle, so a new one waits until the result is loaded
// synchronous active-low reset zeroes both snapshots and empties the result register
`include "assert_macros.svh"

module interpolated_trs_matrix import trs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    trs_in_if.sink    i_req,
    trs_out_if.source o_rsp
);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_ovalid, n_ovalid;
    logic [15:0]       r_alpha;

    logic signed [15:0]       r_q [4];
    logic signed [23:0]       r_s [3];
    logic signed [TW-1:0]     r_t [3];
    logic signed [31:0]       r_p [9];
    logic signed [ROT_W-1:0]  r_rot [9];
    logic signed [ROT_W-1:0]  w_rot [9];
    logic signed [23:0]       r_m [9];
    logic signed [23:0]       r_om [9];
    logic [31:0]              r_ot [3];

    t_snap w_cur, w_prev, w_new;
    logic  w_in_acc, w_push, w_load, w_post;
    logic  w_eval_acc, w_stalled;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod, w_prev_ext, w_blend, w_ent_rnd;
    logic signed [23:0]        w_ent_sat;
    logic [STEP_W-1:0]         w_off, w_pidx, w_poff;

    assign w_in_acc = i_req.valid && i_req.ready;
    assign w_push   = w_in_acc && (i_req.command == CMD_PUSH);
    assign i_req.ready = (r_state == S_IDLE);

    assign w_eval_acc = w_in_acc && (i_req.command == CMD_EVAL);
    assign w_stalled  = (r_state == S_HOLD) && r_ovalid;

    assign w_new.trans[0] = fit_trans(i_req.translation_x);
    assign w_new.trans[1] = fit_trans(i_req.translation_y);
    assign w_new.trans[2] = fit_trans(i_req.translation_z);
    assign w_new.quat[0]  = i_req.quat_w;
    assign w_new.quat[1]  = i_req.quat_x;
    assign w_new.quat[2]  = i_req.quat_y;
    assign w_new.quat[3]  = i_req.quat_z;
    assign w_new.scale[0] = i_req.scale_x;
    assign w_new.scale[1] = i_req.scale_y;
    assign w_new.scale[2] = i_req.scale_z;

    trs_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_new   (w_new),
        .o_cur   (w_cur),
        .o_prev  (w_prev)
    );

    trs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // operand select for the step being issued
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_off   = '0;
        if (r_step < STEP_SBLEND) begin
            w_off   = r_step - STEP_QBLEND;
            w_mul_a = MUL_A_W'($signed(w_cur.quat[w_off[1:0]]))
                    - MUL_A_W'($signed(w_prev.quat[w_off[1:0]]));
            w_mul_b = MUL_B_W'(r_alpha);
        end else if (r_step < STEP_TBLEND) begin
            w_off   = r_step - STEP_SBLEND;
            w_mul_a = MUL_A_W'($signed(w_cur.scale[w_off[1:0]]))
                    - MUL_A_W'($signed(w_prev.scale[w_off[1:0]]));
            w_mul_b = MUL_B_W'(r_alpha);
        end else if (r_step < STEP_QPROD) begin
            w_off   = r_step - STEP_TBLEND;
            w_mul_a = MUL_A_W'($signed(w_cur.trans[w_off[1:0]]))
                    - MUL_A_W'($signed(w_prev.trans[w_off[1:0]]));
            w_mul_b = MUL_B_W'(r_alpha);
        end else if (r_step < STEP_QEND) begin
            w_off   = r_step - STEP_QPROD;
            w_mul_a = MUL_A_W'(r_q[QPAIR_A[w_off[3:0]]]);
            w_mul_b = MUL_B_W'(r_q[QPAIR_B[w_off[3:0]]]);
        end else if (r_step >= STEP_ENTRY && r_step < STEP_LAST) begin
            w_off   = r_step - STEP_ENTRY;
            w_mul_a = MUL_A_W'(r_rot[w_off[3:0]]);
            w_mul_b = r_s[ENTRY_COL[w_off[3:0]]];
        end
    end

    // post stage works on the product issued one step earlier
    always_comb begin
        w_post     = (r_state == S_BUSY) && (r_step != '0);
        w_pidx     = r_step - STEP_W'(1);
        w_poff     = '0;
        w_prev_ext = '0;
        if (w_pidx < STEP_SBLEND) begin
            w_poff     = w_pidx - STEP_QBLEND;
            w_prev_ext = MUL_P_W'($signed(w_prev.quat[w_poff[1:0]]));
        end else if (w_pidx < STEP_TBLEND) begin
            w_poff     = w_pidx - STEP_SBLEND;
            w_prev_ext = MUL_P_W'($signed(w_prev.scale[w_poff[1:0]]));
        end else if (w_pidx < STEP_QPROD) begin
            w_poff     = w_pidx - STEP_TBLEND;
            w_prev_ext = MUL_P_W'($signed(w_prev.trans[w_poff[1:0]]));
        end else if (w_pidx < STEP_QEND) begin
            w_poff = w_pidx - STEP_QPROD;
        end else if (w_pidx >= STEP_ENTRY) begin
            w_poff = w_pidx - STEP_ENTRY;
        end
        w_blend   = ((w_prod + BLEND_HALF) >>> BLEND_SHIFT) + w_prev_ext;
        w_ent_rnd = (w_prod + ENT_HALF) >>> ENT_SHIFT;
        if (w_ent_rnd > MUL_P_W'(ENT_MAX)) begin
            w_ent_sat = ENT_MAX;
        end else if (w_ent_rnd < MUL_P_W'(ENT_MIN)) begin
            w_ent_sat = ENT_MIN;
        end else begin
            w_ent_sat = w_ent_rnd[23:0];
        end
    end

    // rotation entries in q4.30
    always_comb begin
        w_rot[0] = ONE_Q30 - ((ROT_W'(r_p[0]) + ROT_W'(r_p[1])) <<< 1);
        w_rot[1] = (ROT_W'(r_p[3]) - ROT_W'(r_p[4])) <<< 1;
        w_rot[2] = (ROT_W'(r_p[5]) + ROT_W'(r_p[6])) <<< 1;
        w_rot[3] = (ROT_W'(r_p[3]) + ROT_W'(r_p[4])) <<< 1;
        w_rot[4] = ONE_Q30 - ((ROT_W'(r_p[2]) + ROT_W'(r_p[1])) <<< 1);
        w_rot[5] = (ROT_W'(r_p[7]) - ROT_W'(r_p[8])) <<< 1;
        w_rot[6] = (ROT_W'(r_p[5]) - ROT_W'(r_p[6])) <<< 1;
        w_rot[7] = (ROT_W'(r_p[7]) + ROT_W'(r_p[8])) <<< 1;
        w_rot[8] = ONE_Q30 - ((ROT_W'(r_p[2]) + ROT_W'(r_p[0])) <<< 1);
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ovalid = r_ovalid;
        w_load   = 1'b0;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_req.command == CMD_EVAL)) begin
                    n_state = S_BUSY;
                    n_step  = '0;
                end
            end
            S_BUSY: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_HOLD;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_HOLD: begin
                if (!r_ovalid || o_rsp.ready) begin
                    w_load   = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_req.command == CMD_EVAL)) begin
            r_alpha <= sat_alpha(i_req.alpha);
        end
        if (w_post) begin
            if (w_pidx < STEP_SBLEND) begin
                r_q[w_poff[1:0]] <= w_blend[15:0];
            end else if (w_pidx < STEP_TBLEND) begin
                r_s[w_poff[1:0]] <= w_blend[23:0];
            end else if (w_pidx < STEP_QPROD) begin
                r_t[w_poff[1:0]] <= w_blend[TW-1:0];
            end else if (w_pidx < STEP_QEND) begin
                r_p[w_poff[3:0]] <= w_prod[31:0];
            end else if (w_pidx >= STEP_ENTRY && w_pidx < STEP_LAST) begin
                r_m[w_poff[3:0]] <= w_ent_sat;
            end
        end
        if ((r_state == S_BUSY) && (r_step == STEP_ROT)) begin
            for (int i = 0; i < 9; i++) begin
                r_rot[i] <= w_rot[i];
            end
        end
        if (w_load) begin
            for (int i = 0; i < 9; i++) begin
                r_om[i] <= r_m[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_ot[i] <= trans_out(r_t[i]);
            end
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.row0_col0 = r_om[0];
    assign o_rsp.row0_col1 = r_om[1];
    assign o_rsp.row0_col2 = r_om[2];
    assign o_rsp.row0_col3 = r_ot[0];
    assign o_rsp.row1_col0 = r_om[3];
    assign o_rsp.row1_col1 = r_om[4];
    assign o_rsp.row1_col2 = r_om[5];
    assign o_rsp.row1_col3 = r_ot[1];
    assign o_rsp.row2_col0 = r_om[6];
    assign o_rsp.row2_col1 = r_om[7];
    assign o_rsp.row2_col2 = r_om[8];
    assign o_rsp.row2_col3 = r_ot[2];

    `ASSERT_NEXT(a_eval_starts, i_clk, i_rst_n, w_eval_acc, (r_state == S_BUSY) && (r_step == '0))
    `ASSERT_NEXT(a_hold_waits, i_clk, i_rst_n, w_stalled && !o_rsp.ready, w_stalled)
    `ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(o_rsp.valid), $past(r_state) == S_HOLD)

endmodule
